@@ design/assert_macros.svh @@
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that an implication holds at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assert that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

@@ design/rsb10_pkg.sv @@
// ----------------------------------------------------------------------------
// rsb10_pkg
// shared constants and types of the base ten radix sort unit
// ----------------------------------------------------------------------------
package rsb10_pkg;
  localparam int unsigned ValW   = 31;
  localparam int unsigned Radix  = 10;
  localparam int unsigned DigW   = 4;
  localparam int unsigned WeightW = 34;
  typedef logic [ValW-1:0] val_t;
  typedef logic [DigW-1:0] dig_t;
  typedef logic [WeightW-1:0] weight_t;
  typedef struct packed {
    logic start;
    val_t value;
    weight_t weight;
  } dig_req_t;
  typedef struct packed {
    logic done;
    dig_t digit;
  } dig_rsp_t;
endpackage

@@ design/rsb10_ram.sv @@
// ----------------------------------------------------------------------------
// rsb10_ram
// generic simple dual port ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module rsb10_ram #(
  parameter int unsigned Width = 31,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ design/rsb10_digit.sv @@
// ----------------------------------------------------------------------------
// rsb10_digit
// iterative decimal digit extractor: divides by ten once a cycle until the
// weight is reached, then returns the remainder by ten
// ----------------------------------------------------------------------------
module rsb10_digit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsb10_pkg::dig_req_t req_i,
  output rsb10_pkg::dig_rsp_t rsp_o
);
  import rsb10_pkg::*;
  val_t val_q, val_d;
  weight_t w_q, pw_q, pw_d;
  dig_t dig_q, dig_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [63:0] prod;
  val_t quo, rem;
  always_comb begin
    val_d = val_q; pw_d = pw_q; dig_d = dig_q; busy_d = busy_q; done_d = 1'b0;
    // divide by ten through the reciprocal, exact for all 31 bit values
    prod = {33'd0, val_q} * 64'h0000_0000_CCCC_CCCD;
    quo = ValW'(prod >> 35);
    rem = val_q - ((quo << 3) + (quo << 1));
    if (req_i.start) begin
      val_d = req_i.value; pw_d = WeightW'(1); busy_d = 1'b1;
    end else if (busy_q) begin
      if (pw_q == w_q) begin
        dig_d = DigW'(rem); busy_d = 1'b0; done_d = 1'b1;
      end else begin
        val_d = quo; pw_d = (pw_q << 3) + (pw_q << 1);
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d;
    end
  end
  always_ff @(posedge clk_i) begin
    val_q <= val_d; pw_q <= pw_d; dig_q <= dig_d;
    if (req_i.start) w_q <= req_i.weight;
  end
  assign rsp_o.done  = done_q;
  assign rsp_o.digit = dig_q;
endmodule

@@ design/radix_sort_base10_unit.sv @@
// ----------------------------------------------------------------------------
// radix_sort_base10_unit
// lsd radix sort, base ten, over a list held in two synchronous rams
// ----------------------------------------------------------------------------
// usage: list beats enter on s_axis (tdata = value, tlast = final item). beats
// after MAX_ITEMS are dropped. after the tlast beat the block stops accepting
// and runs one counting pass per decimal digit of the largest value. each pass
// walks the list twice (count, then place back to front) and copies scratch
// back. the digit unit divides by ten once a cycle; in both walks an item is
// read from the items ram, its digit extracted, then counted or placed, and
// each pass also forms prefix sums over the ten digit counters before placing.
// the sorted list then leaves on m_axis when the receiver is ready, each beat
// read from the items ram before it is offered, tlast on the final one.
// a stall on m_axis holds the beat; the next list is taken after the last beat.
// while collecting, one beat is accepted per cycle. reset empties the list and
// clears the digit counters; the rams need no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module radix_sort_base10_unit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value[30:0]
  input  logic        s_axis_tlast,  // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // sorted_value[30:0]
  output logic        m_axis_tlast   // end_of_list
);
  import rsb10_pkg::*;
  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [3:0] S_COLL = 4'd0, S_CHK = 4'd1, S_CRD = 4'd2, S_CDIG = 4'd3,
    S_PRE = 4'd4, S_PRD = 4'd5, S_PDIG = 4'd6, S_CPR = 4'd7, S_CPW = 4'd8,
    S_ORD = 4'd9, S_OUT = 4'd10;
  logic [3:0] st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [CW-1:0] bkt_q [Radix];
  val_t max_q, max_d;
  weight_t w_q, w_d;
  logic [3:0] pre_q, pre_d;
  logic a_we, b_we;
  logic [AW-1:0] a_wa, a_ra, b_wa, b_ra;
  val_t a_wd, a_rd, b_rd;
  dig_req_t dreq;
  dig_rsp_t drsp;
  logic inc_en, dec_en, pre_en, clr_en;
  logic rd_issue, start_q;
  val_t in_val;
  assign in_val = s_axis_tdata[ValW-1:0];
  rsb10_ram #(.Width(ValW), .Depth(MAX_ITEMS)) u_items (
    .clk_i, .we_i(a_we), .waddr_i(a_wa), .wdata_i(a_wd), .raddr_i(a_ra), .rdata_o(a_rd));
  rsb10_ram #(.Width(ValW), .Depth(MAX_ITEMS)) u_scratch (
    .clk_i, .we_i(b_we), .waddr_i(b_wa), .wdata_i(a_rd), .raddr_i(b_ra), .rdata_o(b_rd));
  rsb10_digit u_digit (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));
  always_comb begin
    st_d = st_q; cnt_d = cnt_q; idx_d = idx_q; max_d = max_q; w_d = w_q; pre_d = pre_q;
    a_we = 1'b0; a_wa = cnt_q[AW-1:0]; a_wd = in_val; a_ra = idx_q[AW-1:0];
    b_we = 1'b0; b_wa = AW'(bkt_q[drsp.digit] - 1'b1); b_ra = idx_q[AW-1:0];
    dreq.start = start_q; dreq.value = a_rd; dreq.weight = w_q;
    inc_en = 1'b0; dec_en = 1'b0; pre_en = 1'b0; clr_en = 1'b0;
    s_axis_tready = (st_q == S_COLL);
    m_axis_tvalid = (st_q == S_OUT);
    m_axis_tdata = {1'b0, a_rd};
    m_axis_tlast = (idx_q == cnt_q - 1'b1);
    case (st_q)
      S_COLL: if (s_axis_tvalid) begin
        if (cnt_q < CW'(MAX_ITEMS)) begin
          a_we = 1'b1; cnt_d = cnt_q + 1'b1;
          if (in_val > max_q) max_d = in_val;
        end
        if (s_axis_tlast) begin
          st_d = S_CHK; w_d = WeightW'(1);
        end
      end
      S_CHK: begin
        idx_d = '0; clr_en = 1'b1;
        if (WeightW'(max_q) >= w_q) st_d = S_CRD;
        else st_d = S_ORD;
      end
      S_CRD: st_d = S_CDIG;
      S_CDIG: begin
        if (drsp.done) begin
          inc_en = 1'b1;
          if (idx_q + 1'b1 == cnt_q) begin
            st_d = S_PRE; pre_d = 4'd1;
          end else begin
            idx_d = idx_q + 1'b1; st_d = S_CRD;
          end
        end
      end
      S_PRE: begin
        pre_en = 1'b1;
        if (pre_q == 4'(Radix - 1)) begin
          pre_d = 4'd0; idx_d = cnt_q - 1'b1; st_d = S_PRD;
        end else pre_d = pre_q + 1'b1;
      end
      S_PRD: st_d = S_PDIG;
      S_PDIG: begin
        if (drsp.done) begin
          b_we = 1'b1; dec_en = 1'b1;
          if (idx_q == '0) st_d = S_CPR;
          else begin
            idx_d = idx_q - 1'b1; st_d = S_PRD;
          end
        end
      end
      S_CPR: st_d = S_CPW;
      S_CPW: begin
        a_we = 1'b1; a_wa = idx_q[AW-1:0]; a_wd = b_rd;
        if (idx_q + 1'b1 == cnt_q) begin
          st_d = S_CHK;
          w_d = (w_q << 3) + (w_q << 1);
        end else begin
          idx_d = idx_q + 1'b1; st_d = S_CPR;
        end
      end
      S_ORD: st_d = S_OUT;
      S_OUT: if (m_axis_tready) begin
        if (idx_q + 1'b1 == cnt_q) begin
          st_d = S_COLL; cnt_d = '0; max_d = '0;
        end else begin
          idx_d = idx_q + 1'b1; st_d = S_ORD;
        end
      end
      default: st_d = S_COLL;
    endcase
    if (st_q == S_ORD || st_q == S_OUT) a_ra = (st_q == S_OUT && m_axis_tready) ?
      idx_d[AW-1:0] : idx_q[AW-1:0];
  end
  assign rd_issue = (st_q == S_CRD || st_q == S_PRD);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_COLL; cnt_q <= '0; idx_q <= '0; max_q <= '0; w_q <= '0; pre_q <= '0;
      for (int i = 0; i < Radix; i++) bkt_q[i] <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; idx_q <= idx_d; max_q <= max_d; w_q <= w_d;
      pre_q <= pre_d;
      if (clr_en) for (int i = 0; i < Radix; i++) bkt_q[i] <= '0;
      else if (inc_en) bkt_q[drsp.digit] <= bkt_q[drsp.digit] + 1'b1;
      else if (dec_en) bkt_q[drsp.digit] <= bkt_q[drsp.digit] - 1'b1;
      else if (pre_en) bkt_q[pre_q] <= bkt_q[pre_q] + bkt_q[pre_q - 1'b1];
    end
  end
  // the digit unit is started in the cycle after each ram read, once data is valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) start_q <= 1'b0;
    else start_q <= rd_issue;
  end
  `ASSERT_IMPL(a_out_has_items, clk_i, rst_ni, m_axis_tvalid |-> (cnt_q != '0),
    "output beat with empty list")
  `ASSERT_NEVER(a_cnt_over, clk_i, rst_ni, cnt_q > CW'(MAX_ITEMS), "item count overflow")
  `ASSERT_IMPL(a_no_in_busy, clk_i, rst_ni, (st_q != S_COLL) |-> !s_axis_tready,
    "input ready while sorting")
endmodule

@@ tb/sv/radix_sort_base10_checker.sv @@
// ----------------------------------------------------------------------------
// radix_sort_base10_checker
// watches both streams of the radix sort unit, builds each list as it enters,
// predicts the ascending output with the final-beat flag, and compares beats
// ----------------------------------------------------------------------------
module radix_sort_base10_checker #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value[30:0]
  input  logic        s_axis_tlast,  // is_last
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,  // sorted_value[30:0]
  input  logic        m_axis_tlast,  // end_of_list
  output int          pending_o,
  output int          errors_o
);
  import rsb10_pkg::*;

  typedef struct {
    val_t value;
    bit   last;
  } sorted_beat_t;

  val_t         held_list[$];
  sorted_beat_t sorted_q[$];

  assign pending_o = sorted_q.size();

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors_o++;
  endtask

  // ascending order of the held list, tlast on its final entry
  task automatic predict_sorted();
    val_t ordered[$];
    ordered = held_list;
    ordered.sort();
    foreach (ordered[k]) begin
      sorted_q.push_back('{value: ordered[k], last: (k == ordered.size() - 1)});
    end
    held_list.delete();
  endtask

  initial errors_o = 0;

  always @(posedge clk_i) begin
    sorted_beat_t exp_beat;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (held_list.size() < MAX_ITEMS) held_list.push_back(s_axis_tdata[30:0]);
        if (s_axis_tlast) predict_sorted();
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (sorted_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat value %0d", m_axis_tdata[30:0]));
        end else begin
          exp_beat = sorted_q.pop_front();
          if (m_axis_tdata[30:0] !== exp_beat.value)
            report_mismatch($sformatf("value %0d, expected %0d",
                                      m_axis_tdata[30:0], exp_beat.value));
          if (m_axis_tlast !== exp_beat.last)
            report_mismatch($sformatf("tlast %b, expected %b", m_axis_tlast, exp_beat.last));
        end
      end
    end
  end
endmodule

@@ tb/sv/radix_sort_base10_unit_tb.sv @@
// ----------------------------------------------------------------------------
// radix_sort_base10_unit_tb
// feeds directed and random lists into the radix sort unit with random gaps
// and stalls, one long output hold-off, an overflowing list, and a quiet tail
// ----------------------------------------------------------------------------
module radix_sort_base10_unit_tb;
  import rsb10_pkg::*;

  localparam int unsigned MaxItems  = 64;
  localparam int unsigned WatchLim  = 200000;
  localparam int unsigned LongHold  = 3000;
  localparam int unsigned DrainWait = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          pending;
  int          errors;
  bit          calm = 1'b0;
  int          items_sent = 0;
  int          lists_sent = 0;
  int          beats_out = 0;
  int          idle_cycles = 0;

  radix_sort_base10_unit #(.MAX_ITEMS(MaxItems)) uut (.*);

  radix_sort_base10_checker #(.MAX_ITEMS(MaxItems)) u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLim) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold-off once output is flowing
  initial begin
    bit held_off;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) beats_out++;
      if (!held_off && beats_out >= 20 && !calm) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_beat(input val_t value, input bit last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, value};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    if (last) lists_sent++;
  endtask

  function automatic val_t rand_value();
    longint unsigned span;
    int unsigned     ndig;
    ndig = $urandom_range(0, 10);
    if (ndig == 10) return val_t'($urandom);
    span = 1;
    repeat (ndig) span = span * 10;
    return val_t'(longint'($urandom) % span);
  endfunction

  task automatic send_list(input val_t vals[$]);
    foreach (vals[k]) send_beat(vals[k], k == vals.size() - 1);
  endtask

  initial begin
    val_t list_q[$];
    int   len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single zero, extremes with duplicates, all zeros, mixed digit counts
    send_list('{31'd0});
    send_list('{31'h7fffffff, 31'd0, 31'd1, 31'h7fffffff});
    send_list('{31'd0, 31'd0, 31'd0});
    send_list('{31'd9, 31'd81, 31'd702, 31'd6543, 31'd10, 31'd1000000000,
                31'd5, 31'd5, 31'd1999999999, 31'd42});

    while (items_sent < 120) begin
      list_q.delete();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
      repeat (len) list_q.push_back(rand_value());
      send_list(list_q);
    end

    // full buffer plus two beats that must be dropped
    list_q.delete();
    repeat (MaxItems + 2) list_q.push_back(rand_value());
    send_list(list_q);

    calm = 1'b1;
    repeat (6) begin
      list_q.delete();
      repeat ($urandom_range(1, 6)) list_q.push_back(val_t'($urandom));
      send_list(list_q);
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    $display("run covered %0d lists, %0d input beats, %0d sorted beats out",
             lists_sent, items_sent, beats_out);
    $display("including an overflowing list, all-zero lists and a long output stall");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
